/* hdl/decimal_float_adder_unit_assert.svh */
// assertion macros used by the decimal float adder sequencer
`ifndef DECIMAL_FLOAT_ADDER_UNIT_ASSERT_SVH
`define DECIMAL_FLOAT_ADDER_UNIT_ASSERT_SVH

// plain clocked property, masked while reset is high
`define DFA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// same-cycle implication that also needs the previous cycle out of reset
`define DFA_ASSERT_SETTLED(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) \
      ($past(!rst) && (ante)) |-> (cons)) else $error(msg);

`endif

/* hdl/dfa_pkg.sv */
// shared types, constants and helpers of the decimal float adder
`default_nettype none

package dfa_pkg;

   localparam int DIGITS_DEFAULT = 4;

   localparam int MANT_W  = 15;  // signed mantissa fields
   localparam int IEXP_W  = 4;   // operand exponent fields
   localparam int SEXP_W  = 5;   // result exponent field
   localparam int GUARD_W = 4;   // guard digit field
   localparam int EXP_W   = 7;   // internal exponent, covers every reachable value
   localparam int WIDE_W  = 64;  // exact aligned sum
   localparam int CNT_W   = 4;   // alignment decade count

   localparam logic [GUARD_W-1:0] ROUND_HALF = 4'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ADD,
      ST_CHECK,
      ST_DIV_HALF,
      ST_DIV_ACC4,
      ST_DIV_ACC8,
      ST_DIV_ACC16,
      ST_DIV_ACC32,
      ST_DIV_FIX,
      ST_MUL,
      ST_ROUND
   } state_type;

   typedef enum logic [2:0] {
      DIV_NONE,
      DIV_HALF,
      DIV_ACC4,
      DIV_ACC8,
      DIV_ACC16,
      DIV_ACC32,
      DIV_FIX
   } div_op_type;

   typedef struct packed {
      logic       load;
      logic       scale_step;
      logic       add;
      div_op_type div_op;
      logic       mul_step;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic scale_done;
      logic c_zero;
      logic c_ge_top;
      logic c_lt_low;
   } status_type;

   // ten to the n, used at elaboration only
   function automatic logic [WIDE_W-1:0] pow_ten(input int n);
      logic [WIDE_W-1:0] r;
      int i;
      r = 64'd1;
      for (i = 0; i < n; i++) begin
         r = r * 64'd10;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/dfa_ctrl.sv */
// sequencer of the decimal float adder: step order and result handshake
`default_nettype none

`include "decimal_float_adder_unit_assert.svh"

module dfa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output dfa_pkg::cmd_type          cmd,
   input  wire dfa_pkg::status_type  status
);

   dfa_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfa_pkg::ST_IDLE: begin
            if (req_valid) state_in = dfa_pkg::ST_SCALE;
         end
         dfa_pkg::ST_SCALE: begin
            if (status.scale_done) state_in = dfa_pkg::ST_ADD;
         end
         dfa_pkg::ST_ADD: begin
            state_in = dfa_pkg::ST_CHECK;
         end
         dfa_pkg::ST_CHECK: begin
            if (status.c_zero) state_in = dfa_pkg::ST_ROUND;
            else if (status.c_ge_top) state_in = dfa_pkg::ST_DIV_HALF;
            else if (status.c_lt_low) state_in = dfa_pkg::ST_MUL;
            else state_in = dfa_pkg::ST_ROUND;
         end
         dfa_pkg::ST_DIV_HALF:  state_in = dfa_pkg::ST_DIV_ACC4;
         dfa_pkg::ST_DIV_ACC4:  state_in = dfa_pkg::ST_DIV_ACC8;
         dfa_pkg::ST_DIV_ACC8:  state_in = dfa_pkg::ST_DIV_ACC16;
         dfa_pkg::ST_DIV_ACC16: state_in = dfa_pkg::ST_DIV_ACC32;
         dfa_pkg::ST_DIV_ACC32: state_in = dfa_pkg::ST_DIV_FIX;
         dfa_pkg::ST_DIV_FIX:   state_in = dfa_pkg::ST_CHECK;
         dfa_pkg::ST_MUL:       state_in = dfa_pkg::ST_CHECK;
         dfa_pkg::ST_ROUND: begin
            if (out_free) state_in = dfa_pkg::ST_IDLE;
         end
         default: state_in = dfa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         dfa_pkg::ST_IDLE:      cmd.load = req_valid;
         dfa_pkg::ST_SCALE:     cmd.scale_step = !status.scale_done;
         dfa_pkg::ST_ADD:       cmd.add = 1'b1;
         dfa_pkg::ST_DIV_HALF:  cmd.div_op = dfa_pkg::DIV_HALF;
         dfa_pkg::ST_DIV_ACC4:  cmd.div_op = dfa_pkg::DIV_ACC4;
         dfa_pkg::ST_DIV_ACC8:  cmd.div_op = dfa_pkg::DIV_ACC8;
         dfa_pkg::ST_DIV_ACC16: cmd.div_op = dfa_pkg::DIV_ACC16;
         dfa_pkg::ST_DIV_ACC32: cmd.div_op = dfa_pkg::DIV_ACC32;
         dfa_pkg::ST_DIV_FIX:   cmd.div_op = dfa_pkg::DIV_FIX;
         dfa_pkg::ST_MUL:       cmd.mul_step = 1'b1;
         dfa_pkg::ST_ROUND:     cmd.out_load = out_free;
         default: cmd = '0;
      endcase
   end

   // input closed during reset so no beat is taken and dropped
   assign req_stall = reset || (state_ff != dfa_pkg::ST_IDLE);

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DFA_ASSERT(a_accept_busy, clock, reset, (req_valid && !req_stall) |=> req_stall, "accepted beat did not close the input")

   `DFA_ASSERT(a_round_waits, clock, reset, (state_ff == dfa_pkg::ST_ROUND && rsp_valid_ff && rsp_stall) |=> (state_ff == dfa_pkg::ST_ROUND && rsp_valid_ff), "finished sum overran a held result")

   `DFA_ASSERT_SETTLED(a_mul_in_range, clock, reset, ($past(state_ff) == dfa_pkg::ST_MUL && state_ff == dfa_pkg::ST_CHECK), !status.c_ge_top && !status.c_zero, "upscale overshot the digit range")

   `DFA_ASSERT_SETTLED(a_div_in_range, clock, reset, ($past(state_ff) == dfa_pkg::ST_DIV_FIX && state_ff == dfa_pkg::ST_CHECK), !status.c_lt_low && !status.c_zero, "divide by ten fell below the digit range")

endmodule

`default_nettype wire

/* hdl/dfa_datapath.sv */
// datapath of the decimal float adder: align, add, renormalize, round
`default_nettype none

module dfa_datapath #(
   parameter int DIGITS = dfa_pkg::DIGITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire dfa_pkg::cmd_type                     cmd,
   output dfa_pkg::status_type                       status,
   input  wire logic signed [dfa_pkg::MANT_W-1:0]    req_x_mantissa,
   input  wire logic signed [dfa_pkg::IEXP_W-1:0]    req_x_exponent,
   input  wire logic signed [dfa_pkg::MANT_W-1:0]    req_y_mantissa,
   input  wire logic signed [dfa_pkg::IEXP_W-1:0]    req_y_exponent,
   output logic signed [dfa_pkg::MANT_W-1:0]         rsp_sum_mantissa,
   output logic signed [dfa_pkg::SEXP_W-1:0]         rsp_sum_exponent,
   output logic [dfa_pkg::GUARD_W-1:0]               rsp_guard_digit,
   output logic                                      rsp_sum_negative
);

   localparam int MW = dfa_pkg::MANT_W;
   localparam int WW = dfa_pkg::WIDE_W;
   localparam int EW = dfa_pkg::EXP_W;
   localparam int GW = dfa_pkg::GUARD_W;
   localparam int CW = dfa_pkg::CNT_W;
   localparam int IEXP_W_P1 = dfa_pkg::IEXP_W + 1;
   localparam logic [WW-1:0] TOP = dfa_pkg::pow_ten(DIGITS);
   localparam logic [WW-1:0] LOW = dfa_pkg::pow_ten(DIGITS - 1);

   logic [WW-1:0] big_ff, big_in;
   logic [MW-1:0] small_ff, small_in;
   logic          na_ff, na_in, nb_ff, nb_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [EW-1:0] exp_ff, exp_in;
   logic [WW-1:0] c_ff, c_in;
   logic [WW-1:0] q_ff, q_in;
   logic [GW-1:0] guard_ff, guard_in;
   logic          neg_ff, neg_in;
   logic [MW-1:0] mant_ff, mant_in;
   logic [dfa_pkg::SEXP_W-1:0] oexp_ff, oexp_in;
   logic [GW-1:0] oguard_ff, oguard_in;
   logic          oneg_ff, oneg_in;

   // operand split
   logic [MW-1:0] x_bits, y_bits, x_mag, y_mag;
   logic          x_neg, y_neg;
   logic signed [IEXP_W_P1-1:0] shift;
   logic [IEXP_W_P1-1:0] shift_neg;
   logic          shift_pos;

   // add
   logic          same_sign, big_ge;
   logic [WW-1:0] op_hi, op_lo, small_wide;

   // divide-by-ten fixup
   logic [4:0]    q_ten, rem5;
   logic          rem_over;

   // rounding
   logic          round_up, wrap;
   logic [WW-1:0] c_inc, mag_fin;
   logic signed [EW-1:0] exp_fin;

   assign x_bits = unsigned'(req_x_mantissa);
   assign y_bits = unsigned'(req_y_mantissa);
   assign x_neg  = x_bits[MW-1];
   assign y_neg  = y_bits[MW-1];
   assign x_mag  = x_neg ? (~x_bits + {{(MW-1){1'b0}}, 1'b1}) : x_bits;
   assign y_mag  = y_neg ? (~y_bits + {{(MW-1){1'b0}}, 1'b1}) : y_bits;

   assign shift     = {req_x_exponent[dfa_pkg::IEXP_W-1], req_x_exponent}
                    - {req_y_exponent[dfa_pkg::IEXP_W-1], req_y_exponent};
   assign shift_neg = IEXP_W_P1'(-shift);
   assign shift_pos = !shift[IEXP_W_P1-1] && (shift != '0);

   assign small_wide = WW'(small_ff);
   assign same_sign  = (na_ff == nb_ff);
   assign big_ge     = (big_ff >= small_wide);
   assign op_hi      = big_ge ? big_ff : small_wide;
   assign op_lo      = big_ge ? small_wide : big_ff;

   // remainder needs only five bits since it stays below twenty
   assign q_ten    = {q_ff[1:0], 3'b000} + {q_ff[3:0], 1'b0};
   assign rem5     = c_ff[4:0] - q_ten;
   assign rem_over = (rem5 > 5'd9);

   assign round_up = (guard_ff >= dfa_pkg::ROUND_HALF);
   assign c_inc    = c_ff + {{(WW-1){1'b0}}, 1'b1};
   assign wrap     = (c_inc == TOP);
   assign mag_fin  = round_up ? (wrap ? LOW : c_inc) : c_ff;
   assign exp_fin  = exp_ff + EW'(round_up && wrap);

   always_comb begin
      big_in    = big_ff;
      small_in  = small_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      cnt_in    = cnt_ff;
      exp_in    = exp_ff;
      c_in      = c_ff;
      q_in      = q_ff;
      guard_in  = guard_ff;
      neg_in    = neg_ff;
      mant_in   = mant_ff;
      oexp_in   = oexp_ff;
      oguard_in = oguard_ff;
      oneg_in   = oneg_ff;

      if (cmd.load) begin
         guard_in = '0;
         if (shift_pos) begin
            big_in   = WW'(x_mag);
            na_in    = x_neg;
            small_in = y_mag;
            nb_in    = y_neg;
            exp_in   = EW'(req_y_exponent);
            cnt_in   = shift[CW-1:0];
         end else begin
            big_in   = WW'(y_mag);
            na_in    = y_neg;
            small_in = x_mag;
            nb_in    = x_neg;
            exp_in   = EW'(req_x_exponent);
            cnt_in   = shift_neg[CW-1:0];
         end
      end

      if (cmd.scale_step) begin
         big_in = (big_ff << 3) + (big_ff << 1);
         cnt_in = cnt_ff - {{(CW-1){1'b0}}, 1'b1};
      end

      if (cmd.add) begin
         c_in   = same_sign ? (big_ff + small_wide) : (op_hi - op_lo);
         neg_in = (same_sign || big_ge) ? na_ff : nb_ff;
      end

      // reciprocal of ten by shift and add, then one correction
      case (cmd.div_op)
         dfa_pkg::DIV_NONE:  q_in = q_ff;
         dfa_pkg::DIV_HALF:  q_in = (c_ff >> 1) + (c_ff >> 2);
         dfa_pkg::DIV_ACC4:  q_in = q_ff + (q_ff >> 4);
         dfa_pkg::DIV_ACC8:  q_in = q_ff + (q_ff >> 8);
         dfa_pkg::DIV_ACC16: q_in = q_ff + (q_ff >> 16);
         dfa_pkg::DIV_ACC32: q_in = (q_ff + (q_ff >> 32)) >> 3;
         dfa_pkg::DIV_FIX: begin
            c_in     = q_ff + WW'(rem_over);
            guard_in = rem_over ? GW'(rem5 - 5'd10) : rem5[GW-1:0];
            exp_in   = exp_ff + EW'(1);
         end
         default: q_in = q_ff;
      endcase

      if (cmd.mul_step) begin
         c_in   = (c_ff << 3) + (c_ff << 1);
         exp_in = exp_ff - EW'(1);
      end

      if (cmd.out_load) begin
         if (c_ff == '0) begin
            mant_in   = '0;
            oexp_in   = '0;
            oguard_in = '0;
            oneg_in   = 1'b0;
         end else begin
            mant_in   = neg_ff ? (~mag_fin[MW-1:0] + {{(MW-1){1'b0}}, 1'b1})
                               : mag_fin[MW-1:0];
            oexp_in   = exp_fin[dfa_pkg::SEXP_W-1:0];
            oguard_in = guard_ff;
            oneg_in   = neg_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      big_ff    <= big_in;
      small_ff  <= small_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      cnt_ff    <= cnt_in;
      exp_ff    <= exp_in;
      c_ff      <= c_in;
      q_ff      <= q_in;
      guard_ff  <= guard_in;
      neg_ff    <= neg_in;
      mant_ff   <= mant_in;
      oexp_ff   <= oexp_in;
      oguard_ff <= oguard_in;
      oneg_ff   <= oneg_in;
   end

   assign status.scale_done = (cnt_ff == '0);
   assign status.c_zero     = (c_ff == '0);
   assign status.c_ge_top   = (c_ff >= TOP);
   assign status.c_lt_low   = (c_ff < LOW);

   assign rsp_sum_mantissa = signed'(mant_ff);
   assign rsp_sum_exponent = signed'(oexp_ff);
   assign rsp_guard_digit  = oguard_ff;
   assign rsp_sum_negative = oneg_ff;

endmodule

`default_nettype wire

/* hdl/decimal_float_adder_unit.sv */
// top level of the decimal floating-point adder with round half up
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   x_mantissa x_exponent y_mantissa y_exponent
//   rsp      out        rsp_valid/rsp_stall   sum_mantissa sum_exponent guard_digit sum_negative
//
// one operand pair in flight; the time from accept to result grows with |ex - ey| and
// with the divide-by-ten and multiply-by-ten steps of renormalizing; it is set by the
// one-decade-per-cycle align loop and the divider states DIV_HALF through DIV_FIX
// the next pair is taken the cycle after the result is loaded, even while it is stalled
// reset is synchronous and active high; it clears the sequencer and the result valid
// a stalled result holds the finished sum in ROUND until the output register frees up
`default_nettype none

module decimal_float_adder_unit #(
   parameter int DIGITS = dfa_pkg::DIGITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [dfa_pkg::MANT_W-1:0]  req_x_mantissa,
   input  wire logic signed [dfa_pkg::IEXP_W-1:0]  req_x_exponent,
   input  wire logic signed [dfa_pkg::MANT_W-1:0]  req_y_mantissa,
   input  wire logic signed [dfa_pkg::IEXP_W-1:0]  req_y_exponent,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [dfa_pkg::MANT_W-1:0]       rsp_sum_mantissa,
   output logic signed [dfa_pkg::SEXP_W-1:0]       rsp_sum_exponent,
   output logic [dfa_pkg::GUARD_W-1:0]             rsp_guard_digit,
   output logic                                    rsp_sum_negative
);

   // command and status between sequencer and datapath
   dfa_pkg::cmd_type    cmd;
   dfa_pkg::status_type status;

   // sequencer: align count, add, renormalize loop, round and result beat
   dfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: operand split, decade scaling, exact sum, divide by ten, multiply by ten, rounding
   dfa_datapath #(
      .DIGITS (DIGITS)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_x_mantissa   (req_x_mantissa),
      .req_x_exponent   (req_x_exponent),
      .req_y_mantissa   (req_y_mantissa),
      .req_y_exponent   (req_y_exponent),
      .rsp_sum_mantissa (rsp_sum_mantissa),
      .rsp_sum_exponent (rsp_sum_exponent),
      .rsp_guard_digit  (rsp_guard_digit),
      .rsp_sum_negative (rsp_sum_negative)
   );

endmodule

`default_nettype wire
